// ===== design/hedc_pkg.sv =====
// Shared types and constants for the Henon escape / dilatation colorer.
package hedc_pkg;

    // Number formats
    localparam int WORD_W     = 32;            // coordinate word, Q12.20
    localparam int FRAC_W     = 20;            // fraction bits of coordinates
    localparam int MANT_W     = 28;            // Jacobian mantissa magnitude bits
    localparam int JAC_W      = 64;            // Jacobian product width
    localparam int ROOT_W     = 64;            // square-root operand width
    localparam int ROOT_STEPS = ROOT_W / 2;    // one result bit per cell
    localparam int LOG_IN_W   = 33;            // p+q fits in 33 bits
    localparam int LOG_FRAC   = 24;            // log2 fraction bits
    localparam int LOG_EXP_W  = 6;             // integer part of log2
    localparam int LOG_OUT_W  = LOG_EXP_W + LOG_FRAC;
    localparam int LOG_MANT_W = 31;            // Q1.30 mantissa
    localparam int COLOR_W    = 16;
    localparam int NUM_W      = LOG_OUT_W + COLOR_W - LOG_FRAC;
    localparam int ITER_BOUND_DEF = 255;

    localparam logic [LOG_FRAC-1:0] LN2_Q24 = 24'd11629080;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_C       = 3'd0,
        CFG_GAIN_A         = 3'd1,
        CFG_ESCAPE_RADIUS  = 3'd2,
        CFG_COLOR_SCALE    = 3'd3,
        CFG_MAX_ITERATIONS = 3'd4
    } cfg_index_t;

    localparam logic signed [31:0] OFFSET_C_RST       = 32'sd419430;
    localparam logic signed [31:0] GAIN_A_RST         = 32'sd1048576;
    localparam logic [30:0]        ESCAPE_RADIUS_RST  = 31'd104857600;
    localparam logic [15:0]        COLOR_SCALE_RST    = 16'd1000;
    localparam logic [7:0]         MAX_ITERATIONS_RST = 8'd100;

    // Payload of the two data channels
    typedef struct packed {
        logic signed [WORD_W-1:0] start_x;
        logic signed [WORD_W-1:0] start_y;
    } in_item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color_index;
        logic               escaped;
        logic               orientation_reversed;
    } out_item_t;

    // Data handed from one square-root cell to the next
    typedef struct packed {
        logic              valid;
        logic              tag;     // 0: p operand, 1: q operand
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] root;
    } root_stage_t;

endpackage

// ===== design/hedc_root_cell.sv =====
// One cell of the square-root chain: resolves one root bit per transfer.
module hedc_root_cell
    import hedc_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  root_stage_t prev,
    output root_stage_t next
);

    localparam logic [ROOT_W-1:0] BIT_C = ROOT_W'(1) << (ROOT_W - 2 - 2 * STEP);

    logic              valid_reg;
    logic              tag_reg;
    logic [ROOT_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] trial;
    logic [ROOT_W-1:0] rem_next;
    logic [ROOT_W-1:0] root_next;

    always_comb
    begin
        trial = prev.root + BIT_C;
        if (prev.rem >= trial)
        begin
            rem_next  = prev.rem - trial;
            root_next = (prev.root >> 1) + BIT_C;
        end
        else
        begin
            rem_next  = prev.rem;
            root_next = prev.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= prev.valid;
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= prev.tag;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign next = '{valid: valid_reg, tag: tag_reg, rem: rem_reg, root: root_reg};

endmodule

// ===== design/hedc_log_unit.sv =====
// Iterative log2 by repeated squaring, one fraction bit per cycle.
module hedc_log_unit
    import hedc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [LOG_IN_W-1:0]  value,
    output logic                 done,
    output logic [LOG_OUT_W-1:0] result
);

    localparam int CNT_W = $clog2(LOG_FRAC + 1);
    localparam int MFRAC = LOG_MANT_W - 1;

    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [LOG_MANT_W-1:0] m_reg;
    logic [LOG_MANT_W-1:0] m_next;
    logic [LOG_EXP_W-1:0]  exp_reg;
    logic [LOG_EXP_W-1:0]  exp_next;
    logic [LOG_FRAC-1:0]   frac_reg;
    logic [LOG_FRAC-1:0]   frac_next;
    logic [LOG_IN_W-1:0]   norm;
    logic [2*LOG_MANT_W-1:0] sq;
    logic [LOG_MANT_W:0]   sq_top;

    // leading one and normalization to Q1.30
    always_comb
    begin
        exp_next = '0;
        for (int b = 0; b < LOG_IN_W; b++)
        begin
            if (value[b])
                exp_next = LOG_EXP_W'(b);
        end
        if (exp_next > LOG_EXP_W'(MFRAC))
            norm = value >> (exp_next - LOG_EXP_W'(MFRAC));
        else
            norm = value << (LOG_EXP_W'(MFRAC) - exp_next);
    end

    // one squaring step
    always_comb
    begin
        sq     = m_reg * m_reg;
        sq_top = sq[2*LOG_MANT_W-1:MFRAC];
        frac_next = {frac_reg[LOG_FRAC-2:0], sq_top[LOG_MANT_W]};
        if (sq_top[LOG_MANT_W])
            m_next = sq_top[LOG_MANT_W:1];
        else
            m_next = sq_top[LOG_MANT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(LOG_FRAC);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            m_reg    <= norm[LOG_MANT_W-1:0];
            exp_reg  <= exp_next;
            frac_reg <= '0;
        end
        else if (busy_reg)
        begin
            m_reg    <= m_next;
            frac_reg <= frac_next;
        end
    end

    assign done   = done_reg;
    assign result = {exp_reg, frac_reg};

endmodule

// ===== design/henon_escape_dilatation_color.sv =====
// Top level: Henon orbit with Jacobian tracking, dilatation color back end.
//
//  channel | signals                              | moves
//  --------+--------------------------------------+-------------------------------
//  in      | in_valid, in_ready, in_data          | one start point per transfer
//  out     | out_valid, out_ready, out_data       | one color result per transfer
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | one register write per transfer
//
//  A point escapes after i steps, or stays inside for lim steps (lim =
//  min(max_iterations, ITER_BOUND)). Each map step has two states: multiply,
//  then Jacobian renormalize. The back end is the 32-cell square-root chain,
//  log2 by repeated squaring and a 22-step divide.
//  Reset clears control and restores the register defaults; no clearing pass.
//  A finished result waits in the output register while the next point starts.
module henon_escape_dilatation_color
    import hedc_pkg::*;
#(
    parameter int ITER_BOUND = ITER_BOUND_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(ITER_BOUND + 1);
    localparam int LIM_W = (CNT_W < 8) ? CNT_W : 8;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [CMP_W-1:0] BOUND_C = CMP_W'(ITER_BOUND);
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int SUM_W = MANT_W + 2;     // signed sum of two entries
    localparam int SMAG_W = MANT_W + 1;    // its magnitude
    localparam int SQ_W = 2 * SMAG_W;
    localparam int RES_W = ROOT_STEPS;     // root result width
    localparam int LNK_PROD_W = LOG_OUT_W + LOG_FRAC;
    localparam int SCL_PROD_W = LOG_OUT_W + COLOR_W;
    localparam int RW = 2 * WORD_W - FRAC_W;

    localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [RW-1:0] R_POS_LIM = RW'(WMAX);
    localparam logic [RW-1:0] R_NEG_LIM = RW'(1) << (WORD_W - 1);
    localparam logic signed [MANT_W:0] D_ONE = {2'b01, {(MANT_W-1){1'b0}}};
    localparam logic [COLOR_W-2:0] COLOR_SAT = {(COLOR_W-1){1'b1}};

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_MUL   = 14'b00000000000010,
        S_NORM  = 14'b00000000000100,
        S_SUMS  = 14'b00000000001000,
        S_SQ    = 14'b00000000010000,
        S_FEEDP = 14'b00000000100000,
        S_FEEDQ = 14'b00000001000000,
        S_ROOT  = 14'b00000010000000,
        S_CMP   = 14'b00000100000000,
        S_LOG   = 14'b00001000000000,
        S_LN    = 14'b00010000000000,
        S_SCALE = 14'b00100000000000,
        S_DIV   = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } state_t;

    // saturating Q12.20 multiply, truncated toward zero
    function automatic logic signed [WORD_W-1:0] qmul(input logic signed [WORD_W-1:0] a,
                                                      input logic signed [WORD_W-1:0] b);
        logic signed [2*WORD_W-1:0] prod;
        logic [2*WORD_W-1:0]        pm;
        logic [RW-1:0]              r;
        logic signed [WORD_W-1:0]   res;
        prod = a * b;
        pm   = prod[2*WORD_W-1] ? (~prod + 1'b1) : prod;
        r    = pm[2*WORD_W-1:FRAC_W];
        if (!prod[2*WORD_W-1])
            res = (r > R_POS_LIM) ? WMAX : r[WORD_W-1:0];
        else
            res = (r > R_NEG_LIM) ? WMIN : (~r[WORD_W-1:0] + 1'b1);
        return res;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0]   s;
        logic signed [WORD_W-1:0] res;
        s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
        if (s[WORD_W:WORD_W-1] == 2'b01)
            res = WMAX;
        else if (s[WORD_W:WORD_W-1] == 2'b10)
            res = WMIN;
        else
            res = s[WORD_W-1:0];
        return res;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_sub(input logic signed [WORD_W-1:0] a,
                                                         input logic signed [WORD_W-1:0] b);
        logic signed [WORD_W:0]   s;
        logic signed [WORD_W-1:0] res;
        s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
        if (s[WORD_W:WORD_W-1] == 2'b01)
            res = WMAX;
        else if (s[WORD_W:WORD_W-1] == 2'b10)
            res = WMIN;
        else
            res = s[WORD_W-1:0];
        return res;
    endfunction

    // configuration registers
    logic signed [31:0] offset_c_reg;
    logic signed [31:0] gain_a_reg;
    logic [30:0]        radius_reg;
    logic [15:0]        scale_reg;
    logic [7:0]         max_iter_reg;

    // control
    state_t     state_reg, state_next;
    logic [LIM_W-1:0] iter_reg, iter_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    // datapath
    logic signed [WORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [MANT_W:0]   d_reg [4];
    logic signed [MANT_W:0]   d_next [4];
    logic signed [JAC_W-1:0]  e_reg [4];
    logic signed [JAC_W-1:0]  e_next [4];
    logic [SMAG_W-1:0]        sm_reg [4];
    logic [SMAG_W-1:0]        sm_next [4];
    logic [SQ_W-1:0]          sq_reg [4];
    logic [SQ_W-1:0]          sq_next [4];
    logic [RES_W-1:0]         p_reg, p_next, q_reg, q_next;
    logic [LOG_OUT_W-1:0]     lnk_reg, lnk_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [LIM_W-1:0]         rem_reg, rem_next;
    out_item_t                res_reg, res_next;
    out_item_t                out_data_reg, out_data_next;

    // combinational helpers
    logic [CMP_W-1:0]  lim_full;
    logic [LIM_W-1:0]  lim;
    logic [WORD_W-1:0] mag_x, mag_y;
    logic              more, in_region, out_free;
    logic signed [WORD_W-1:0] ny;
    logic signed [WORD_W:0]   c1, c2;
    logic signed [JAC_W-1:0]  e_calc [4];
    logic signed [MANT_W:0]   d_norm [4];
    logic [JAC_W-1:0]  mag_e [4];
    logic [JAC_W-1:0]  mag_or;
    logic [6:0]        len;
    logic [5:0]        sh;
    logic [JAC_W-1:0]  tmp;
    logic signed [SUM_W-1:0] sums [4];
    logic [SUM_W-1:0]  smag [4];
    logic [LOG_IN_W-1:0] log_sum, log_diff;
    logic              log_start, log_done_a, log_done_b;
    logic [LOG_OUT_W-1:0] l1, l2, dl;
    logic [LNK_PROD_W-1:0] lnk_prod;
    logic [SCL_PROD_W-1:0] scl_prod;
    logic [LIM_W:0]    trial;
    logic              qbit;
    logic [COLOR_W-2:0] fsat;
    root_stage_t       root_chain [ROOT_STEPS+1];
    root_stage_t       root_out;

    assign lim_full = (CMP_W'(max_iter_reg) < BOUND_C) ? CMP_W'(max_iter_reg) : BOUND_C;
    assign lim      = lim_full[LIM_W-1:0];
    assign mag_x    = x_reg[WORD_W-1] ? (~x_reg + 1'b1) : x_reg;
    assign mag_y    = y_reg[WORD_W-1] ? (~y_reg + 1'b1) : y_reg;
    assign more     = iter_reg < lim;
    assign in_region = more && ((mag_x > mag_y) || (mag_y < {1'b0, radius_reg}));
    assign out_free = !out_valid_reg || out_ready;

    // map step: y' = sat(sat(y*y + c) - a*x)
    assign ny = sat_sub(sat_add(qmul(y_reg, y_reg), offset_c_reg), qmul(gain_a_reg, x_reg));

    // Jacobian step J*D, J = [[0, 1], [-a, 2y]] with 1 = 2^FRAC_W; a 32-bit word
    // never forces a pre-shift of the step matrix
    always_comb
    begin
        c1 = -{gain_a_reg[WORD_W-1], gain_a_reg};
        c2 = {y_reg, 1'b0};
        e_calc[0] = JAC_W'(d_reg[2]) <<< FRAC_W;
        e_calc[1] = JAC_W'(d_reg[3]) <<< FRAC_W;
        e_calc[2] = c1 * d_reg[0] + c2 * d_reg[2];
        e_calc[3] = c1 * d_reg[1] + c2 * d_reg[3];
    end

    // renormalize so the largest magnitude has exactly MANT_W bits
    always_comb
    begin
        mag_or = '0;
        len    = '0;
        sh     = '0;
        tmp    = '0;
        for (int k = 0; k < 4; k++)
        begin
            mag_e[k] = e_reg[k][JAC_W-1] ? (~e_reg[k] + 1'b1) : e_reg[k];
            mag_or   = mag_or | mag_e[k];
        end
        for (int b = 0; b < JAC_W; b++)
        begin
            if (mag_or[b])
                len = 7'(b + 1);
        end
        for (int k = 0; k < 4; k++)
        begin
            if (len > 7'(MANT_W))
            begin
                sh  = 6'(len - 7'(MANT_W));
                tmp = mag_e[k] >> sh;
                d_norm[k] = e_reg[k][JAC_W-1] ? (~tmp[MANT_W:0] + 1'b1) : tmp[MANT_W:0];
            end
            else if (len != 7'd0)
            begin
                sh  = 6'(7'(MANT_W) - len);
                tmp = e_reg[k] << sh;
                d_norm[k] = tmp[MANT_W:0];
            end
            else
                d_norm[k] = '0;
        end
    end

    // sums of the conformal and anti-conformal parts
    always_comb
    begin
        sums[0] = d_reg[0] + d_reg[3];
        sums[1] = d_reg[2] - d_reg[1];
        sums[2] = d_reg[0] - d_reg[3];
        sums[3] = d_reg[2] + d_reg[1];
        for (int k = 0; k < 4; k++)
        begin
            smag[k]    = sums[k][SUM_W-1] ? (~sums[k] + 1'b1) : sums[k];
            sm_next[k] = smag[k][SMAG_W-1:0];
            sq_next[k] = sm_reg[k] * sm_reg[k];
        end
    end

    // square-root chain: p operand, then q operand in the cycle after it
    assign root_chain[0] = '{
        valid: (state_reg == S_FEEDP) || (state_reg == S_FEEDQ),
        tag:   (state_reg == S_FEEDQ),
        rem:   (state_reg == S_FEEDQ)
               ? {1'b0, (SQ_W+1)'(sq_reg[2]) + (SQ_W+1)'(sq_reg[3]), 4'b0000}
               : {1'b0, (SQ_W+1)'(sq_reg[0]) + (SQ_W+1)'(sq_reg[1]), 4'b0000},
        root:  '0
    };

    for (genvar g = 0; g < ROOT_STEPS; g++)
    begin : g_root
        hedc_root_cell #(.STEP(g)) u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .prev  (root_chain[g]),
            .next  (root_chain[g+1])
        );
    end

    assign root_out = root_chain[ROOT_STEPS];

    // log2(p+q) and log2(p-q) side by side
    assign log_start = (state_reg == S_CMP) && (p_reg > q_reg);
    assign log_sum   = {1'b0, p_reg} + {1'b0, q_reg};
    assign log_diff  = {1'b0, p_reg - q_reg};

    hedc_log_unit u_log_sum
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .value  (log_sum),
        .done   (log_done_a),
        .result (l1)
    );

    hedc_log_unit u_log_diff
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .value  (log_diff),
        .done   (log_done_b),
        .result (l2)
    );

    // ln K and scaling, then restoring divide by lim
    assign dl       = (l1 > l2) ? (l1 - l2) : '0;
    assign lnk_prod = dl * LN2_Q24;
    assign scl_prod = lnk_reg * scale_reg;
    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign qbit     = trial >= {1'b0, lim};
    assign fsat     = (num_reg > NUM_W'(COLOR_SAT)) ? COLOR_SAT : num_reg[COLOR_W-2:0];

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        lnk_next   = lnk_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        res_next   = res_reg;
        for (int k = 0; k < 4; k++)
        begin
            d_next[k] = d_reg[k];
            e_next[k] = e_reg[k];
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next    = in_data.start_x;
                    y_next    = in_data.start_y;
                    d_next[0] = D_ONE;
                    d_next[1] = '0;
                    d_next[2] = '0;
                    d_next[3] = D_ONE;
                    iter_next = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (in_region)
                begin
                    x_next    = y_reg;
                    y_next    = ny;
                    for (int k = 0; k < 4; k++)
                        e_next[k] = e_calc[k];
                    iter_next  = iter_reg + 1'b1;
                    state_next = S_NORM;
                end
                else if (more)
                begin
                    res_next = '{color_index: COLOR_W'({iter_reg, 1'b0}),
                                 escaped: 1'b1, orientation_reversed: 1'b0};
                    state_next = S_IDLE;
                end
                else
                    state_next = S_SUMS;
            end
            S_NORM:
            begin
                for (int k = 0; k < 4; k++)
                    d_next[k] = d_norm[k];
                state_next = S_MUL;
            end
            S_SUMS:  state_next = S_SQ;
            S_SQ:    state_next = S_FEEDP;
            S_FEEDP: state_next = S_FEEDQ;
            S_FEEDQ: state_next = S_ROOT;
            S_ROOT:
            begin
                if (root_out.valid && !root_out.tag)
                    p_next = root_out.root[RES_W-1:0];
                if (root_out.valid && root_out.tag)
                begin
                    q_next     = root_out.root[RES_W-1:0];
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (q_reg >= p_reg)
                begin
                    // k >= 1, dilatation undefined
                    res_next = '{color_index: COLOR_W'(1), escaped: 1'b0,
                                 orientation_reversed: 1'b1};
                    state_next = S_IDLE;
                end
                else
                    state_next = S_LOG;
            end
            S_LOG:
            begin
                if (log_done_a)
                    state_next = S_LN;
            end
            S_LN:
            begin
                lnk_next   = lnk_prod[LNK_PROD_W-1:LOG_FRAC];
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                num_next = scl_prod[SCL_PROD_W-1:LOG_FRAC];
                rem_next = '0;
                cnt_next = DIV_CNT_W'(NUM_W);
                if (lim == '0)
                begin
                    // no limit: color value is zero
                    res_next = '{color_index: COLOR_W'(1), escaped: 1'b0,
                                 orientation_reversed: 1'b0};
                    state_next = S_IDLE;
                end
                else
                    state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = qbit ? LIM_W'(trial - {1'b0, lim}) : trial[LIM_W-1:0];
                num_next = {num_reg[NUM_W-2:0], qbit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                res_next = '{color_index: {fsat, 1'b1}, escaped: 1'b0,
                             orientation_reversed: 1'b0};
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        // finished results go to the output slot; hold if it is still full
        if ((state_next == S_IDLE) && (state_reg != S_IDLE) && !out_free)
            state_next = state_reg;
    end

    // hand a finished result to the output register
    logic result_ready;
    assign result_ready = (state_reg != S_IDLE) && (state_next == S_IDLE);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_next;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        lnk_reg      <= lnk_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        for (int k = 0; k < 4; k++)
        begin
            d_reg[k]  <= d_next[k];
            e_reg[k]  <= e_next[k];
            sm_reg[k] <= (state_reg == S_SUMS) ? sm_next[k] : sm_reg[k];
            sq_reg[k] <= (state_reg == S_SQ) ? sq_next[k] : sq_reg[k];
        end
    end

    // configuration writes, always accepted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_c_reg <= OFFSET_C_RST;
            gain_a_reg   <= GAIN_A_RST;
            radius_reg   <= ESCAPE_RADIUS_RST;
            scale_reg    <= COLOR_SCALE_RST;
            max_iter_reg <= MAX_ITERATIONS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OFFSET_C:       offset_c_reg <= cfg_data[31:0];
                CFG_GAIN_A:         gain_a_reg   <= cfg_data[31:0];
                CFG_ESCAPE_RADIUS:  radius_reg   <= cfg_data[30:0];
                CFG_COLOR_SCALE:    scale_reg    <= cfg_data[15:0];
                CFG_MAX_ITERATIONS: max_iter_reg <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_iter_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> (iter_reg <= lim))
        else $error("iteration count beyond limit");

    a_root_order: assert property (@(posedge clk) disable iff (!rst_n)
        (root_out.valid && root_out.tag) |-> $past(root_out.valid && !root_out.tag))
        else $error("q root without preceding p root");

    a_escape_color: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.escaped) |->
        (!out_data.orientation_reversed && !out_data.color_index[0]))
        else $error("escape result not even or flagged reversed");

    a_log_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        log_done_a == log_done_b)
        else $error("log units out of step");

    a_start_iter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MUL))
        else $error("accepted point did not start the orbit");
`endif

endmodule
